### hw/rtl/ctw_pkg.sv
`default_nettype none
package ctw_pkg;

  localparam int DEFAULT_COLS = 40;
  localparam int DEFAULT_ROWS = 24;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_CR   = 8'h0d;
  localparam logic [7:0] CODE_LOW  = 8'h20;
  localparam logic [7:0] CODE_HIGH = 8'hfe;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_A   = 8'h61;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_HEX  = 2'd1,
    CMD_READ = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    OP_PRINT  = 3'd0,
    OP_BACK   = 3'd1,
    OP_ENTER  = 3'd2,
    OP_SKIP   = 3'd3,
    OP_READ   = 3'd4,
    OP_REPORT = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] payload;
    logic [4:0]  read_row;
    logic [5:0]  read_col;
  } command_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic       repaint;
  } result_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] code;
    logic [4:0] row;
    logic [5:0] col;
    logic       last;
    logic       repaint;
  } op_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'd0, nib};
    if (nib < 4'd10) return DIGIT_0 + n;
    else return DIGIT_A + n - 8'd10;
  endfunction

  function automatic op_kind_t classify(input logic [7:0] code);
    if (code >= CODE_LOW && code <= CODE_HIGH) return OP_PRINT;
    else if (code == CODE_BS) return OP_BACK;
    else if (code == CODE_CR) return OP_ENTER;
    else return OP_SKIP;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ctw_ram.sv
`default_nettype none
module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 960
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/ctw_queue.sv
`default_nettype none
module ctw_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire ctw_pkg::op_t           push_op,
  input  wire logic                   pop,
  output ctw_pkg::op_t                head,
  output ctw_pkg::queue_status_t      status
);
  import ctw_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.valid = (count != '0);
  assign head         = mem[rp];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ctw_front.sv
`default_nettype none
module ctw_front #(
  parameter int SCREEN_COLS = ctw_pkg::DEFAULT_COLS,
  parameter int SCREEN_ROWS = ctw_pkg::DEFAULT_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire ctw_pkg::command_t      command,
  output logic                        busy,
  input  wire ctw_pkg::queue_status_t q_status,
  input  wire ctw_pkg::back_status_t  back_status,
  output logic                        push,
  output ctw_pkg::op_t                push_op
);
  import ctw_pkg::*;

  logic        hex_active;
  logic [31:0] hex_val;
  logic [2:0]  hex_cnt;
  logic        accept;
  logic        in_range;

  assign busy     = back_status.clearing || hex_active || q_status.full;
  assign accept   = start && !busy;
  assign in_range = (int'(command.read_row) < SCREEN_ROWS) &&
                    (int'(command.read_col) < SCREEN_COLS);

  always_comb begin
    push            = 1'b0;
    push_op.kind    = OP_REPORT;
    push_op.code    = command.payload[7:0];
    push_op.row     = command.read_row;
    push_op.col     = command.read_col;
    push_op.last    = 1'b1;
    push_op.repaint = 1'b0;
    if (hex_active) begin
      push            = !q_status.full;
      push_op.kind    = OP_PRINT;
      push_op.code    = hex_char(hex_val[31:28]);
      push_op.last    = (hex_cnt == 3'd7);
      push_op.repaint = 1'b1;
    end else if (accept) begin
      unique case (command.cmd)
        CMD_PUT: begin
          push            = 1'b1;
          push_op.kind    = classify(command.payload[7:0]);
          push_op.repaint = 1'b1;
        end
        CMD_HEX: begin
          push = 1'b0;
        end
        CMD_READ: begin
          push         = 1'b1;
          push_op.kind = in_range ? OP_READ : OP_REPORT;
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_active <= 1'b0;
      hex_cnt    <= '0;
    end else if (hex_active) begin
      if (!q_status.full) begin
        hex_val <= {hex_val[27:0], 4'd0};
        hex_cnt <= hex_cnt + 1'b1;
        if (hex_cnt == 3'd7) hex_active <= 1'b0;
      end
    end else if (accept && command.cmd == CMD_HEX) begin
      hex_active <= 1'b1;
      hex_val    <= command.payload;
      hex_cnt    <= '0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ctw_back.sv
`default_nettype none
module ctw_back #(
  parameter int SCREEN_COLS = ctw_pkg::DEFAULT_COLS,
  parameter int SCREEN_ROWS = ctw_pkg::DEFAULT_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctw_pkg::op_t           head,
  input  wire ctw_pkg::queue_status_t q_status,
  output logic                        pop,
  output ctw_pkg::back_status_t       status,
  output logic                        done,
  output ctw_pkg::result_t            result
);
  import ctw_pkg::*;

  localparam int CELLS     = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(SCREEN_ROWS);
  localparam int COL_W     = $clog2(SCREEN_COLS);
  localparam int LAST_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;

  typedef enum logic [4:0] {
    B_CLEAR  = 5'b00001,
    B_IDLE   = 5'b00010,
    B_READ   = 5'b00100,
    B_SCROLL = 5'b01000,
    B_DRAIN  = 5'b10000
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic              scroll_go;
  logic [ADDR_W-1:0] idx;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_idx;
  logic              wr_copy;
  logic              fin_pend;
  logic              fin_repaint;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] read_addr;
  logic              at_home;
  logic              last_col;
  logic              last_row;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign cur_addr  = ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
  assign read_addr = ADDR_W'(head.row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(head.col);
  assign at_home   = (row == '0) && (col == '0);
  assign last_col  = (col == COL_W'(SCREEN_COLS - 1));
  assign last_row  = (row == ROW_W'(SCREEN_ROWS - 1));
  assign pop       = (state == B_IDLE);
  assign status.clearing = (state == B_CLEAR);

  ctw_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // cursor update for the op at the queue head
  always_comb begin
    row_next  = row;
    col_next  = col;
    scroll_go = 1'b0;
    unique case (head.kind)
      OP_PRINT: begin
        if (last_col) begin
          col_next = '0;
          if (last_row) scroll_go = 1'b1;
          else row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      OP_BACK: begin
        if (col != '0) begin
          col_next = col - 1'b1;
        end else if (row != '0) begin
          row_next = row - 1'b1;
          col_next = COL_W'(SCREEN_COLS - 1);
        end
      end
      OP_ENTER: begin
        col_next = '0;
        if (last_row) scroll_go = 1'b1;
        else row_next = row + 1'b1;
      end
      default: begin
        scroll_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = head.code;
    raddr = read_addr;
    unique case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = '0;
      end
      B_IDLE: begin
        if (q_status.valid && head.kind == OP_PRINT) begin
          we = 1'b1;
        end else if (q_status.valid && head.kind == OP_BACK && !at_home) begin
          we    = 1'b1;
          waddr = cur_addr - 1'b1;
          wdata = '0;
        end
      end
      B_READ: begin
        we = 1'b0;
      end
      B_SCROLL, B_DRAIN: begin
        raddr = idx + ADDR_W'(SCREEN_COLS);
        we    = wr_pend;
        waddr = wr_idx;
        wdata = wr_copy ? rdata : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      idx      <= '0;
      row      <= '0;
      col      <= '0;
      wr_pend  <= 1'b0;
      fin_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          done <= 1'b0;
          if (idx == ADDR_W'(CELLS - 1)) begin
            idx   <= '0;
            state <= B_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_IDLE: begin
          if (q_status.valid) begin
            row <= row_next;
            col <= col_next;
            result.cell_char  <= '0;
            result.cursor_row <= 5'(row_next);
            result.cursor_col <= 6'(col_next);
            result.repaint    <= head.repaint;
            if (head.kind == OP_READ) begin
              done  <= 1'b0;
              state <= B_READ;
            end else if (scroll_go) begin
              done        <= 1'b0;
              state       <= B_SCROLL;
              idx         <= '0;
              wr_pend     <= 1'b0;
              fin_pend    <= head.last;
              fin_repaint <= head.repaint;
            end else begin
              done <= head.last;
            end
          end else begin
            done <= 1'b0;
          end
        end
        B_READ: begin
          done             <= 1'b1;
          result.cell_char <= rdata;
          result.repaint   <= 1'b0;
          state            <= B_IDLE;
        end
        B_SCROLL: begin
          done    <= 1'b0;
          wr_pend <= 1'b1;
          wr_idx  <= idx;
          wr_copy <= (int'(idx) < LAST_BASE);
          idx     <= idx + 1'b1;
          if (idx == ADDR_W'(CELLS - 1)) state <= B_DRAIN;
        end
        B_DRAIN: begin
          wr_pend           <= 1'b0;
          done              <= fin_pend;
          result.cell_char  <= '0;
          result.cursor_row <= 5'(row);
          result.cursor_col <= 6'(col);
          result.repaint    <= fin_repaint;
          state             <= B_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= B_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("back state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    (int'(row) < SCREEN_ROWS) && (int'(col) < SCREEN_COLS))
    else $error("cursor outside screen");
  assert property (@(posedge clk) disable iff (rst)
    state == B_CLEAR |-> !done)
    else $error("transfer during clearing pass");
  assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == B_SCROLL || state == B_DRAIN))
    else $error("scroll write outside scroll");
  assert property (@(posedge clk) disable iff (rst)
    state == B_SCROLL |=> !done)
    else $error("transfer in the middle of a scroll");

endmodule
`default_nettype wire

### hw/rtl/text_console_writer.sv
`default_nettype none
// Text console writer: a SCREEN_ROWS x SCREEN_COLS character screen with a cursor.
// Commands are taken when start is high and busy is low; each command gives exactly one
// result, shown on result for the single cycle in which done is high, and the receiver
// cannot hold it off. Up to four character operations queue between the command side and
// the screen side. A put or an ignored code is one operation on the screen side, a read
// passes through the read state as well, and a hex print is eight character operations. A
// character that overflows the bottom row, or a carriage return on it, scrolls the screen,
// which sweeps the screen memory one cell per cycle. After reset busy stays high while the
// memory is cleared one cell per cycle.
module text_console_writer #(
  parameter int SCREEN_COLS = ctw_pkg::DEFAULT_COLS,
  parameter int SCREEN_ROWS = ctw_pkg::DEFAULT_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire ctw_pkg::command_t command,
  output logic                   busy,
  output logic                   done,
  output ctw_pkg::result_t       result
);
  import ctw_pkg::*;

  queue_status_t q_status;
  back_status_t  back_status;
  logic          push;
  op_t           push_op;
  logic          pop;
  op_t           head;

  ctw_front #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .busy       (busy),
    .q_status   (q_status),
    .back_status(back_status),
    .push       (push),
    .push_op    (push_op)
  );

  ctw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  ctw_back #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_status(q_status),
    .pop     (pop),
    .status  (back_status),
    .done    (done),
    .result  (result)
  );

endmodule
`default_nettype wire

### bench/text_console_writer_tb.sv
module text_console_writer_tb;
  import ctw_pkg::*;

  localparam int COLS = DEFAULT_COLS;
  localparam int ROWS = DEFAULT_ROWS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STREAM_ITEMS = 600;
  localparam int SETTLE_CYCLES = 1000;

  typedef struct {
    command_t cmd;
    int       gap;
    bit       drain;
  } backlog_item_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  command_t command = '0;
  logic     busy;
  logic     done;
  result_t  result;

  backlog_item_t cmd_backlog[$];
  result_t       expected_results[$];
  logic [7:0]    screen_model[ROWS*COLS];
  int            cur_row = 0;
  int            cur_col = 0;
  int            err_count = 0;
  int            result_count = 0;
  int            idle_left = 0;
  logic          start_taken = 1'b0;

  text_console_writer u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #4 clk = ~clk;

  task automatic note_failure(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void advance_row();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) screen_model[i] = 8'h00;
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic void apply_code(input logic [7:0] c);
    if (c >= CODE_LOW && c <= CODE_HIGH) begin
      screen_model[cur_row * COLS + cur_col] = c;
      if (cur_col + 1 >= COLS) advance_row();
      else cur_col++;
    end else if (c == CODE_BS) begin
      if (cur_col != 0) begin
        cur_col--;
      end else if (cur_row != 0) begin
        cur_row--;
        cur_col = COLS - 1;
      end else begin
        return;
      end
      screen_model[cur_row * COLS + cur_col] = 8'h00;
    end else if (c == CODE_CR) begin
      advance_row();
    end
  endfunction

  function automatic result_t predict_console(input command_t c);
    result_t     r;
    logic [31:0] v;
    logic [3:0]  nib;
    r = '0;
    case (c.cmd)
      CMD_PUT: begin
        apply_code(c.payload[7:0]);
        r.repaint = 1'b1;
      end
      CMD_HEX: begin
        v = c.payload;
        for (int i = 0; i < 8; i++) begin
          nib = v[31:28];
          apply_code((nib < 4'd10) ? "0" + nib : "a" + nib - 8'd10);
          v = v << 4;
        end
        r.repaint = 1'b1;
      end
      CMD_READ: begin
        if (c.read_row < ROWS && c.read_col < COLS)
          r.cell_char = screen_model[c.read_row * COLS + c.read_col];
      end
      default: ;
    endcase
    r.cursor_row = cur_row[4:0];
    r.cursor_col = cur_col[5:0];
    return r;
  endfunction

  // transfer at the rising edge, checks before new expectations
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      start_taken <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result %h", result));
        end else begin
          want = expected_results.pop_front();
          if (result.cell_char !== want.cell_char)
            note_failure($sformatf("result %0d cell_char got %h want %h",
                                   result_count, result.cell_char, want.cell_char));
          if (result.cursor_row !== want.cursor_row)
            note_failure($sformatf("result %0d cursor_row got %0d want %0d",
                                   result_count, result.cursor_row, want.cursor_row));
          if (result.cursor_col !== want.cursor_col)
            note_failure($sformatf("result %0d cursor_col got %0d want %0d",
                                   result_count, result.cursor_col, want.cursor_col));
          if (result.repaint !== want.repaint)
            note_failure($sformatf("result %0d repaint got %b want %b",
                                   result_count, result.repaint, want.repaint));
        end
        result_count <= result_count + 1;
      end
      start_taken <= start && !busy;
      if (start && !busy) expected_results.push_back(predict_console(command));
    end
  end

  always @(negedge clk) begin : drive
    backlog_item_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (!(start && !start_taken)) begin
      if (idle_left != 0) begin
        start <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_backlog[0].drain) begin
        start <= 1'b0;
        if (expected_results.size() == 0) void'(cmd_backlog.pop_front());
      end else begin
        nxt = cmd_backlog.pop_front();
        start <= 1'b1;
        command <= nxt.cmd;
        idle_left <= nxt.gap;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] c, input logic [31:0] p, input logic [4:0] r,
                           input logic [5:0] col, input int gap);
    backlog_item_t it;
    it.cmd.cmd = c;
    it.cmd.payload = p;
    it.cmd.read_row = (c == CMD_READ) ? r : 5'($urandom_range(0, 31));
    it.cmd.read_col = (c == CMD_READ) ? col : 6'($urandom_range(0, 63));
    it.gap = gap;
    it.drain = 1'b0;
    cmd_backlog.push_back(it);
  endtask

  task automatic queue_drain();
    backlog_item_t it;
    it.cmd = '0;
    it.gap = 0;
    it.drain = 1'b1;
    cmd_backlog.push_back(it);
  endtask

  function automatic int pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] printable_payload();
    return {24'($urandom_range(0, 32'hff_ffff)),
            8'($urandom_range(CODE_LOW, CODE_HIGH))};
  endfunction

  initial begin : stimulus
    int  issued;
    int  len;
    bit  burst;
    for (int i = 0; i < ROWS * COLS; i++) screen_model[i] = 8'h00;

    // directed corners
    queue_cmd(CMD_READ, $urandom, 5'd0, 6'd0, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd31, 6'd63, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd24, 6'd5, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd3, 6'd40, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_BS}, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_LOW}, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, {24'hff_ffff, CODE_HIGH}, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, 32'h0000_001f, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, 32'h0000_00ff, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, 32'h0000_0000, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, 32'h5a5a_a57f, 0, 0, pick_gap(0));
    queue_cmd(CMD_HEX, 32'h0123_4567, 0, 0, pick_gap(0));
    queue_cmd(CMD_HEX, 32'h89ab_cdef, 0, 0, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd0, 6'd1, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_BS}, 0, 0, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd0, 6'd18, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_CR}, 0, 0, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_BS}, 0, 0, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd0, 6'd39, pick_gap(0));
    queue_cmd(CMD_HEX, 32'hffff_ffff, 0, 0, pick_gap(0));
    queue_cmd(CMD_HEX, 32'h0000_0000, 0, 0, pick_gap(0));
    queue_cmd(CMD_UNUSED, 32'h0000_0041, 0, 0, pick_gap(0));
    queue_cmd(CMD_READ, $urandom, 5'd23, 6'd39, pick_gap(0));
    queue_cmd(CMD_PUT, {24'h0, CODE_CR}, 0, 0, pick_gap(0));
    queue_drain();

    // random stream shaped as lines of text with edits, dumps, reads and noise
    issued = 0;
    while (issued < STREAM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 8);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
              queue_cmd(CMD_PUT, {24'($urandom), CODE_BS}, 0, 0, pick_gap(burst));
            else
              queue_cmd(CMD_PUT, printable_payload(), 0, 0, pick_gap(burst));
          end
          issued += len;
          if ($urandom_range(0, 3) != 0) begin
            queue_cmd(CMD_PUT, {24'($urandom), CODE_CR}, 0, 0, pick_gap(burst));
            issued++;
          end
        end
        5: begin
          queue_cmd(CMD_HEX, $urandom, 0, 0, pick_gap(burst));
          issued++;
        end
        6, 7: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0)
              queue_cmd(CMD_READ, $urandom, 5'($urandom_range(0, 31)),
                        6'($urandom_range(0, 63)), pick_gap(burst));
            else
              queue_cmd(CMD_READ, $urandom, 5'($urandom_range(0, ROWS - 1)),
                        6'($urandom_range(0, COLS - 1)), pick_gap(burst));
          end
          issued += len;
        end
        8: begin
          queue_cmd(2'($urandom_range(0, 3)), $urandom, 5'($urandom_range(0, 31)),
                    6'($urandom_range(0, 63)), pick_gap(burst));
          issued++;
        end
        default: begin
          len = $urandom_range(1, 45);
          for (int i = 0; i < len; i++)
            queue_cmd(CMD_PUT, {24'($urandom), CODE_BS}, 0, 0, pick_gap(burst));
          issued += len;
        end
      endcase
      if ($urandom_range(0, 39) == 0) queue_drain();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
